@@ design/two_link_gear_kinematics_to_pixel_assert.svh @@
// Assertion macros for the two-link gear kinematics block.
// Define ASSERT_OFF to compile the assertions out.
`ifndef TWO_LINK_GEAR_KINEMATICS_TO_PIXEL_ASSERT_SVH
`define TWO_LINK_GEAR_KINEMATICS_TO_PIXEL_ASSERT_SVH
`ifndef ASSERT_OFF
`define TLGK_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define TLGK_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);
`else
`define TLGK_ASSERT(label, prop, msg)
`define TLGK_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

@@ design/tlgk_pkg.sv @@
package tlgk_pkg;

   localparam int PHASE_FRAC_BITS = 16;
   localparam int TURN_BITS       = 4;
   localparam int PIXEL_BITS      = 12;

   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_ORBIT_LEN      = 3'd0,
      REG_ARM_LEN        = 3'd1,
      REG_INV_GEAR_RATIO = 3'd2,
      REG_PIXEL_SCALE    = 3'd3,
      REG_PIXEL_CENTER   = 3'd4
   } csr_index_type;

   localparam logic [15:0]           ORBIT_LEN_RESET      = 16'd9884;
   localparam logic [15:0]           ARM_LEN_RESET        = 16'd9884;
   localparam logic [15:0]           INV_GEAR_RATIO_RESET = 16'd16384;
   localparam logic [15:0]           PIXEL_SCALE_RESET    = 16'd24398;
   localparam logic [PIXEL_BITS-1:0] PIXEL_CENTER_RESET   = PIXEL_BITS'(460);

   // Sine evaluation: quarter-turn fraction scaled to Q30, Horner polynomial.
   localparam int QW      = PHASE_FRAC_BITS - 2;   // fraction bits within a quadrant
   localparam int FW      = PHASE_FRAC_BITS - 1;   // fraction width that can hold a quarter
   localparam int XW      = 31;                    // Q30 operand width
   localparam int PW      = 31;                    // Horner partial width
   localparam int MW      = XW + PW;               // product width
   localparam int SIN_LAT = 8;                     // register stages in the sine unit
   localparam int SIN_W   = 18;                    // signed Q16 sine, -1.0 .. +1.0

   localparam logic [FW-1:0] QUARTER = FW'(1) << QW;

   localparam logic [PW-1:0] C9 = 31'd172272;
   localparam logic [PW-1:0] HORNER_C [4] = '{31'd5026996, 31'd85569306,
                                              31'd693598668, 31'd1686629713};

   localparam logic [18:0] SIN_ONE_U = 19'd65536;
   localparam logic signed [SIN_W-1:0] SIN_ONE = 18'sd65536;

   // Gear product and pixel mapping widths.
   localparam int RATIO_FRAC = 16;
   localparam int DIFF_W     = PHASE_FRAC_BITS + TURN_BITS + 1;
   localparam int GEAR_W     = RATIO_FRAC + PHASE_FRAC_BITS;
   localparam int POS_W      = 18;
   localparam int LPROD_W    = 35;
   localparam int PIX_SHIFT  = 20;
   localparam int PIX_VW     = (PIXEL_BITS + 22 > 36) ? PIXEL_BITS + 22 : 36;

endpackage

@@ design/tlgk_sin.sv @@
module tlgk_sin (
   input  logic                                clock,
   input  logic                                en,
   input  logic [tlgk_pkg::PHASE_FRAC_BITS-1:0] phase,
   output logic signed [tlgk_pkg::SIN_W-1:0]    sine
);
   import tlgk_pkg::*;

   logic [FW-1:0]  f_raw;
   logic [FW-1:0]  f1_in;
   logic [FW-1:0]  f1_ff;
   logic [1:0]     quad_ff [1:7];
   logic [XW-1:0]  x_ff    [2:6];
   logic [XW-1:0]  x_in;
   logic [PW-1:0]  x2_ff   [2:5];
   logic [MW-1:0]  x2_prod;
   logic [PW-1:0]  p_ff    [3:6];
   logic [PW-1:0]  p_in    [4];
   logic [PW-1:0]  mcand   [4];
   logic [MW-1:0]  hprod   [4];
   logic [MW-1:0]  s_prod;
   logic [31:0]    s_ff;
   logic [32:0]    s_round;
   logic [18:0]    q_raw;
   logic [18:0]    q_cap;
   logic signed [SIN_W-1:0] sine_in;
   logic signed [SIN_W-1:0] sine_ff;

   // Odd quadrants run the fraction backwards from the quarter point.
   assign f_raw = FW'(phase[QW-1:0]);
   assign f1_in = phase[QW] ? (QUARTER - f_raw) : f_raw;

   assign x_in    = XW'(f1_ff) << (32 - PHASE_FRAC_BITS);
   assign x2_prod = MW'(x_in) * MW'(x_in);

   always_comb begin
      mcand[0] = C9;
      for (int k = 1; k < 4; k++) begin
         mcand[k] = p_ff[2 + k];
      end
      for (int k = 0; k < 4; k++) begin
         hprod[k] = MW'(x2_ff[2 + k]) * MW'(mcand[k]);
         p_in[k]  = HORNER_C[k] - PW'(hprod[k] >> 30);
      end
   end

   assign s_prod  = MW'(x_ff[6]) * MW'(p_ff[6]);
   assign s_round = 33'(s_ff) + 33'd8192;
   assign q_raw   = s_round[32:14];
   assign q_cap   = (q_raw > SIN_ONE_U) ? SIN_ONE_U : q_raw;
   assign sine_in = quad_ff[7][1] ? -$signed(SIN_W'(q_cap)) : $signed(SIN_W'(q_cap));

   always_ff @(posedge clock) begin
      if (en) begin
         f1_ff      <= f1_in;
         quad_ff[1] <= phase[PHASE_FRAC_BITS-1:PHASE_FRAC_BITS-2];
         for (int k = 2; k <= 7; k++) begin
            quad_ff[k] <= quad_ff[k - 1];
         end
         x_ff[2]  <= x_in;
         x2_ff[2] <= PW'(x2_prod >> 30);
         for (int k = 3; k <= 6; k++) begin
            x_ff[k] <= x_ff[k - 1];
         end
         for (int k = 3; k <= 5; k++) begin
            x2_ff[k] <= x2_ff[k - 1];
         end
         for (int k = 0; k < 4; k++) begin
            p_ff[3 + k] <= p_in[k];
         end
         s_ff    <= 32'(s_prod >> 30);
         sine_ff <= sine_in;
      end
   end

   assign sine = sine_ff;

endmodule

@@ design/two_link_gear_kinematics_to_pixel.sv @@
// Forward kinematics of a two-link planetary gear: from a sun phase and an earth
// driver phase each beat yields the earth centre, the earth phase, the wand tip
// and the tip's saturated pixel. The block is a fixed pipeline of 15 register
// stages: two for the gear product, eight in each of four parallel sine units
// (sun sine and cosine, earth sine and cosine), and five for the length
// products, rounding, tip sum, pixel product and pixel saturation. A beat can
// enter every clock unless stalled, so throughput is one item per cycle. The
// whole pipeline holds as one while the output register carries a result that
// is stalled. Configuration registers are read directly by the stages that use
// them and should be written only while the pipeline is empty.
`include "two_link_gear_kinematics_to_pixel_assert.svh"

module two_link_gear_kinematics_to_pixel (
   input  logic                                             clock,
   input  logic                                             reset,
   input  logic                                             req_valid,
   output logic                                             req_stall,
   input  logic [tlgk_pkg::PHASE_FRAC_BITS-1:0]              req_sun_phase,
   input  logic [tlgk_pkg::PHASE_FRAC_BITS+tlgk_pkg::TURN_BITS-1:0] req_driver_phase,
   output logic                                             rsp_valid,
   input  logic                                             rsp_stall,
   output logic signed [tlgk_pkg::POS_W-1:0]                 rsp_earth_x,
   output logic signed [tlgk_pkg::POS_W-1:0]                 rsp_earth_y,
   output logic [tlgk_pkg::PHASE_FRAC_BITS-1:0]              rsp_earth_phase,
   output logic signed [tlgk_pkg::POS_W-1:0]                 rsp_tip_x,
   output logic signed [tlgk_pkg::POS_W-1:0]                 rsp_tip_y,
   output logic [tlgk_pkg::PIXEL_BITS-1:0]                   rsp_pixel_x,
   output logic [tlgk_pkg::PIXEL_BITS-1:0]                   rsp_pixel_y,
   input  logic                                             csr_write_en,
   input  logic [tlgk_pkg::CSR_INDEX_W-1:0]                  csr_index,
   input  logic [tlgk_pkg::CSR_DATA_W-1:0]                   csr_data
);
   import tlgk_pkg::*;

   localparam int P = PHASE_FRAC_BITS;

   // Configuration registers.
   logic [15:0]           orbit_len_ff;
   logic [15:0]           arm_len_ff;
   logic [15:0]           inv_gear_ratio_ff;
   logic [15:0]           pixel_scale_ff;
   logic [PIXEL_BITS-1:0] pixel_center_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         orbit_len_ff      <= ORBIT_LEN_RESET;
         arm_len_ff        <= ARM_LEN_RESET;
         inv_gear_ratio_ff <= INV_GEAR_RATIO_RESET;
         pixel_scale_ff    <= PIXEL_SCALE_RESET;
         pixel_center_ff   <= PIXEL_CENTER_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            REG_ORBIT_LEN:      orbit_len_ff      <= csr_data[15:0];
            REG_ARM_LEN:        arm_len_ff        <= csr_data[15:0];
            REG_INV_GEAR_RATIO: inv_gear_ratio_ff <= csr_data[15:0];
            REG_PIXEL_SCALE:    pixel_scale_ff    <= csr_data[15:0];
            REG_PIXEL_CENTER:   pixel_center_ff   <= csr_data[PIXEL_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // Every stage moves together; only a stalled result in the output register
   // holds the pipeline.
   logic adv;
   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   logic accept;
   assign accept = req_valid && adv;

   // Stage A: phase difference, sun minus driver, as a signed value.
   logic                     va_ff;
   logic [P-1:0]             sun_a_ff;
   logic signed [DIFF_W-1:0] diff_a_ff;
   logic [DIFF_W-1:0]        diff_in;

   assign diff_in = DIFF_W'(req_sun_phase) - DIFF_W'(req_driver_phase);

   // Stage B: earth phase is the difference times the reciprocal ratio.
   logic              vb_ff;
   logic [P-1:0]      sun_b_ff;
   logic [P-1:0]      earth_b_ff;
   logic [GEAR_W-1:0] gear_prod;

   assign gear_prod = GEAR_W'(diff_a_ff) * GEAR_W'(inv_gear_ratio_ff);

   // Four sine units run side by side; cosine is the sine a quarter turn on.
   logic [P-1:0]             sun_cos_ph;
   logic [P-1:0]             earth_cos_ph;
   logic signed [SIN_W-1:0]  sin_sun;
   logic signed [SIN_W-1:0]  cos_sun;
   logic signed [SIN_W-1:0]  sin_earth;
   logic signed [SIN_W-1:0]  cos_earth;

   assign sun_cos_ph   = sun_b_ff + P'(QUARTER);
   assign earth_cos_ph = earth_b_ff + P'(QUARTER);

   tlgk_sin u_sin_sun   (.clock(clock), .en(adv), .phase(sun_b_ff),     .sine(sin_sun));
   tlgk_sin u_cos_sun   (.clock(clock), .en(adv), .phase(sun_cos_ph),   .sine(cos_sun));
   tlgk_sin u_sin_earth (.clock(clock), .en(adv), .phase(earth_b_ff),   .sine(sin_earth));
   tlgk_sin u_cos_earth (.clock(clock), .en(adv), .phase(earth_cos_ph), .sine(cos_earth));

   logic [SIN_LAT-1:0] vs_ff;
   logic [P-1:0]       earth_d_ff [SIN_LAT];

   // Stage L: length times sine or cosine, Q28.
   logic                      vl_ff;
   logic [P-1:0]              earth_l_ff;
   logic signed [LPROD_W-1:0] lex_ff, ley_ff, lax_ff, lay_ff;

   // Stage R: rounded half up to Q12.
   logic                    vr_ff;
   logic [P-1:0]            earth_r_ff;
   logic signed [POS_W-1:0] ex_r_ff, ey_r_ff, ax_r_ff, ay_r_ff;

   function automatic logic signed [POS_W-1:0] round_q12(
      input logic signed [LPROD_W-1:0] v
   );
      logic signed [LPROD_W-1:0] b;
      b = v + LPROD_W'(32768);
      return POS_W'(b >>> 16);
   endfunction

   // Stage T: tip is earth centre plus arm.
   logic                    vt_ff;
   logic [P-1:0]            earth_t_ff;
   logic signed [POS_W-1:0] ex_t_ff, ey_t_ff, tx_t_ff, ty_t_ff;

   // Stage P: pixel scale times tip.
   logic                      vp_ff;
   logic [P-1:0]              earth_p_ff;
   logic signed [POS_W-1:0]   ex_p_ff, ey_p_ff, tx_p_ff, ty_p_ff;
   logic signed [LPROD_W-1:0] px_p_ff, py_p_ff;

   // Output stage: add the centre, floor to a pixel and saturate.
   function automatic logic [PIXEL_BITS-1:0] to_pixel(
      input logic signed [LPROD_W-1:0]  prod,
      input logic [PIXEL_BITS-1:0]      center
   );
      logic signed [PIX_VW-1:0] v;
      v = PIX_VW'(prod) + (PIX_VW'(center) << PIX_SHIFT);
      if (v[PIX_VW-1]) begin
         return '0;
      end else if (|v[PIX_VW-2:PIX_SHIFT+PIXEL_BITS]) begin
         return '1;
      end else begin
         return v[PIX_SHIFT+PIXEL_BITS-1:PIX_SHIFT];
      end
   endfunction

   logic rsp_valid_ff;

   // Valid bits, reset to empty.
   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff        <= 1'b0;
         vb_ff        <= 1'b0;
         vs_ff        <= '0;
         vl_ff        <= 1'b0;
         vr_ff        <= 1'b0;
         vt_ff        <= 1'b0;
         vp_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         va_ff        <= accept;
         vb_ff        <= va_ff;
         vs_ff        <= {vs_ff[SIN_LAT-2:0], vb_ff};
         vl_ff        <= vs_ff[SIN_LAT-1];
         vr_ff        <= vl_ff;
         vt_ff        <= vr_ff;
         vp_ff        <= vt_ff;
         rsp_valid_ff <= vp_ff;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (adv) begin
         sun_a_ff  <= req_sun_phase;
         diff_a_ff <= $signed(diff_in);

         sun_b_ff   <= sun_a_ff;
         earth_b_ff <= gear_prod[GEAR_W-1:RATIO_FRAC];

         earth_d_ff[0] <= earth_b_ff;
         for (int k = 1; k < SIN_LAT; k++) begin
            earth_d_ff[k] <= earth_d_ff[k - 1];
         end

         earth_l_ff <= earth_d_ff[SIN_LAT-1];
         lex_ff <= $signed({1'b0, orbit_len_ff}) * sin_sun;
         ley_ff <= $signed({1'b0, orbit_len_ff}) * cos_sun;
         lax_ff <= $signed({1'b0, arm_len_ff}) * sin_earth;
         lay_ff <= $signed({1'b0, arm_len_ff}) * cos_earth;

         earth_r_ff <= earth_l_ff;
         ex_r_ff <= round_q12(lex_ff);
         ey_r_ff <= round_q12(ley_ff);
         ax_r_ff <= round_q12(lax_ff);
         ay_r_ff <= round_q12(lay_ff);

         earth_t_ff <= earth_r_ff;
         ex_t_ff <= ex_r_ff;
         ey_t_ff <= ey_r_ff;
         tx_t_ff <= ex_r_ff + ax_r_ff;
         ty_t_ff <= ey_r_ff + ay_r_ff;

         earth_p_ff <= earth_t_ff;
         ex_p_ff <= ex_t_ff;
         ey_p_ff <= ey_t_ff;
         tx_p_ff <= tx_t_ff;
         ty_p_ff <= ty_t_ff;
         px_p_ff <= $signed({1'b0, pixel_scale_ff}) * tx_t_ff;
         py_p_ff <= $signed({1'b0, pixel_scale_ff}) * ty_t_ff;

         rsp_earth_phase <= earth_p_ff;
         rsp_earth_x     <= ex_p_ff;
         rsp_earth_y     <= ey_p_ff;
         rsp_tip_x       <= tx_p_ff;
         rsp_tip_y       <= ty_p_ff;
         rsp_pixel_x     <= to_pixel(px_p_ff, pixel_center_ff);
         rsp_pixel_y     <= to_pixel(py_p_ff, pixel_center_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // An accepted beat always lands in the first stage.
   `TLGK_ASSERT_NEXT(a_accept_enters, req_valid && !req_stall, va_ff, "accepted beat lost")
   // A stalled result freezes the stage behind it.
   `TLGK_ASSERT_NEXT(a_stall_holds, rsp_valid && rsp_stall, $stable(vp_ff) && $stable(rsp_tip_x), "pipeline moved under stall")
   // Sine units never exceed unit magnitude.
   `TLGK_ASSERT(a_sine_range, vs_ff[SIN_LAT-1] |-> (sin_earth >= -SIN_ONE && sin_earth <= SIN_ONE), "sine out of range")

endmodule
